[rtl/core/merge_sort_engine_assert.svh]
// Assertion macros shared by the merge sort engine RTL.
// Needs signals clk and arst_n in the scope where a macro is used.
`ifndef MERGE_SORT_ENGINE_ASSERT_SVH
`define MERGE_SORT_ENGINE_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define MSE_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define MSE_ASSERT_NEXT(lbl, ante, cons, msg) \
	`MSE_ASSERT(lbl, (ante) |=> (cons), msg)
`else
`define MSE_ASSERT(lbl, prop, msg)
`define MSE_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

[rtl/core/mse_pkg.sv]
// Types and constants of the merge sort engine.
// No dependencies; used by mse_mem, mse_seq and merge_sort_engine.
package mse_pkg;

	localparam int DATA_W = 32;

	typedef logic signed [DATA_W-1:0] word_t;

	// Result beat handed from the sequencer to the output register.
	typedef struct packed {
		logic  valid;
		word_t value;
		logic  last;
	} emit_t;

endpackage

[rtl/core/mse_mem.sv]
// Element memory of the merge sort engine: one write port, two read ports,
// read data registered. Depends on mse_pkg.
module mse_mem #(
	parameter int DEPTH = 128
) (
	input  logic                       clk,
	input  logic                       wr_en,
	input  logic [$clog2(DEPTH)-1:0]   wr_addr,
	input  mse_pkg::word_t             wr_data,
	input  logic [$clog2(DEPTH)-1:0]   rd_addr_a,
	input  logic [$clog2(DEPTH)-1:0]   rd_addr_b,
	output mse_pkg::word_t             rd_data_a,
	output mse_pkg::word_t             rd_data_b
);
	import mse_pkg::*;

	word_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_a <= mem[rd_addr_a];
		rd_data_b <= mem[rd_addr_b];
	end

endmodule

[rtl/core/mse_seq.sv]
// Sequencer of the merge sort engine: loads a set, runs bottom-up merge passes
// between two memory banks and reads the sorted set out. Depends on mse_pkg.
`include "merge_sort_engine_assert.svh"

module mse_seq #(
	parameter int MAX_ELEMENTS = 64
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  mse_pkg::word_t                    in_value,
	input  logic                              in_last,
	output mse_pkg::emit_t                    emit,
	input  logic                              out_free,
	output logic                              wr_en,
	output logic [$clog2(MAX_ELEMENTS):0]     wr_addr,
	output mse_pkg::word_t                    wr_data,
	output logic [$clog2(MAX_ELEMENTS):0]     rd_addr_a,
	output logic [$clog2(MAX_ELEMENTS):0]     rd_addr_b,
	input  mse_pkg::word_t                    rd_data_a,
	input  mse_pkg::word_t                    rd_data_b
);
	import mse_pkg::*;

	localparam int AW = $clog2(MAX_ELEMENTS);
	localparam int CW = $clog2(MAX_ELEMENTS + 1);
	localparam int SW = CW + 2;
	localparam logic [CW-1:0] MAX_CNT = CW'(MAX_ELEMENTS);

	localparam logic [2:0] ST_LOAD = 3'd0;
	localparam logic [2:0] ST_PASS = 3'd1;
	localparam logic [2:0] ST_RUN  = 3'd2;
	localparam logic [2:0] ST_RD   = 3'd3;
	localparam logic [2:0] ST_MG   = 3'd4;
	localparam logic [2:0] ST_ORD  = 3'd5;
	localparam logic [2:0] ST_OWT  = 3'd6;

	logic [2:0]    state_q;
	logic [CW-1:0] n_q;
	logic [CW-1:0] i_q;
	logic [SW-1:0] width_q;
	logic [SW-1:0] lo_q;
	logic [SW-1:0] mid_q;
	logic [SW-1:0] hi_q;
	logic [SW-1:0] l_q;
	logic [SW-1:0] r_q;
	logic [SW-1:0] k_q;
	logic          src_q;

	logic [SW-1:0] n_ext;
	logic [SW-1:0] mid_sum;
	logic [SW-1:0] hi_sum;
	logic [SW-1:0] mid_c;
	logic [SW-1:0] hi_c;
	logic [SW-1:0] k_next;
	logic          take_left;
	logic          last_c;
	logic          store_ok;

	assign n_ext     = SW'(n_q);
	assign mid_sum   = lo_q + width_q;
	assign hi_sum    = lo_q + (width_q << 1);
	assign mid_c     = (mid_sum > n_ext) ? n_ext : mid_sum;
	assign hi_c      = (hi_sum > n_ext) ? n_ext : hi_sum;
	assign k_next    = k_q + SW'(1);
	assign take_left = (l_q < mid_q) && ((r_q >= hi_q) || (rd_data_a <= rd_data_b));
	assign last_c    = (i_q + CW'(1)) == n_q;
	assign store_ok  = n_q != MAX_CNT;

	assign in_ready = state_q == ST_LOAD;

	assign emit.valid = (state_q == ST_OWT) && out_free;
	assign emit.value = rd_data_a;
	assign emit.last  = last_c;

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = {1'b0, n_q[AW-1:0]};
		wr_data = in_value;
		if (state_q == ST_LOAD) begin
			wr_en = in_valid && store_ok;
		end else if (state_q == ST_MG) begin
			wr_en   = 1'b1;
			wr_addr = {~src_q, k_q[AW-1:0]};
			wr_data = take_left ? rd_data_a : rd_data_b;
		end
	end

	always_comb begin
		rd_addr_b = {src_q, r_q[AW-1:0]};
		if ((state_q == ST_ORD) || (state_q == ST_OWT)) begin
			rd_addr_a = {src_q, i_q[AW-1:0]};
		end else begin
			rd_addr_a = {src_q, l_q[AW-1:0]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			n_q     <= '0;
			i_q     <= '0;
			width_q <= '0;
			lo_q    <= '0;
			mid_q   <= '0;
			hi_q    <= '0;
			l_q     <= '0;
			r_q     <= '0;
			k_q     <= '0;
			src_q   <= 1'b0;
		end else begin
			case (state_q)
				ST_LOAD: begin
					if (in_valid) begin
						if (store_ok) begin
							n_q <= n_q + CW'(1);
						end
						if (in_last) begin
							src_q   <= 1'b0;
							width_q <= SW'(1);
							state_q <= ST_PASS;
						end
					end
				end
				ST_PASS: begin
					if (width_q >= n_ext) begin
						i_q     <= '0;
						state_q <= ST_ORD;
					end else begin
						lo_q    <= '0;
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (lo_q >= n_ext) begin
						src_q   <= ~src_q;
						width_q <= width_q << 1;
						state_q <= ST_PASS;
					end else begin
						l_q     <= lo_q;
						r_q     <= mid_c;
						k_q     <= lo_q;
						mid_q   <= mid_c;
						hi_q    <= hi_c;
						state_q <= ST_RD;
					end
				end
				ST_RD: begin
					state_q <= ST_MG;
				end
				ST_MG: begin
					if (take_left) begin
						l_q <= l_q + SW'(1);
					end else begin
						r_q <= r_q + SW'(1);
					end
					k_q <= k_next;
					if (k_next == hi_q) begin
						lo_q    <= hi_q;
						state_q <= ST_RUN;
					end else begin
						state_q <= ST_RD;
					end
				end
				ST_ORD: begin
					state_q <= ST_OWT;
				end
				ST_OWT: begin
					if (out_free) begin
						i_q <= i_q + CW'(1);
						if (last_c) begin
							n_q     <= '0;
							state_q <= ST_LOAD;
						end else begin
							state_q <= ST_ORD;
						end
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	`MSE_ASSERT(a_count_bound, n_q <= MAX_CNT, "element count above capacity")
	`MSE_ASSERT(a_merge_in_run, (state_q == ST_MG) |-> ((k_q < hi_q) && ((l_q < mid_q) || (r_q < hi_q))), "merge step outside its run")
	`MSE_ASSERT_NEXT(a_set_done, emit.valid && emit.last, (n_q == '0) && (state_q == ST_LOAD), "set not cleared after last beat")

endmodule

[rtl/core/merge_sort_engine.sv]
// Merge sort engine: collects one set of signed 32-bit values, ending with the beat that has
// tlast set, then sorts the set in ascending order (stable) and streams it out, tlast on the
// last value. Values beyond MAX_ELEMENTS in a set are dropped. While loading, input beats are
// accepted back to back. For n stored values the sort takes ceil(log2 n) passes, and every merge
// step waits for one registered read of the memory. The output steps through a read state and
// a wait state per beat, and holds in the wait state while the output register stays occupied.
// No input is taken from the set's last beat until its last result has been handed to the
// output register. Depends on mse_pkg, mse_mem and mse_seq.
module merge_sort_engine #(
	parameter int MAX_ELEMENTS = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  mse_pkg::word_t        s_axis_tdata,   // [31:0] sample_value
	input  logic                  s_axis_tlast,   // set_end
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output mse_pkg::word_t        m_axis_tdata,   // [31:0] sorted_value
	output logic                  m_axis_tlast    // final_flag
);
	import mse_pkg::*;

	localparam int MEM_AW = $clog2(MAX_ELEMENTS) + 1;

	emit_t             emit;
	logic              out_free;
	logic              wr_en;
	logic [MEM_AW-1:0] wr_addr;
	word_t             wr_data;
	logic [MEM_AW-1:0] rd_addr_a;
	logic [MEM_AW-1:0] rd_addr_b;
	word_t             rd_data_a;
	word_t             rd_data_b;

	logic  out_valid_q;
	word_t out_data_q;
	logic  out_last_q;

	assign out_free      = !out_valid_q || m_axis_tready;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tlast  = out_last_q;

	mse_seq #(
		.MAX_ELEMENTS(MAX_ELEMENTS)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_value  (s_axis_tdata),
		.in_last   (s_axis_tlast),
		.emit      (emit),
		.out_free  (out_free),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.rd_addr_a (rd_addr_a),
		.rd_addr_b (rd_addr_b),
		.rd_data_a (rd_data_a),
		.rd_data_b (rd_data_b)
	);

	mse_mem #(
		.DEPTH(2 ** MEM_AW)
	) u_mem (
		.clk       (clk),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.rd_addr_a (rd_addr_a),
		.rd_addr_b (rd_addr_b),
		.rd_data_a (rd_data_a),
		.rd_data_b (rd_data_b)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit.valid) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit.valid) begin
			out_data_q <= emit.value;
			out_last_q <= emit.last;
		end
	end

endmodule

[tb/sv/merge_sort_engine_test.sv]
// Self-checking testbench for merge_sort_engine: sends sets of signed values, predicts the
// sorted output of each set and compares every output beat with the oldest expected one.
// Depends on mse_pkg and the merge_sort_engine RTL.
module merge_sort_engine_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH = 64;
	localparam int STALL_LIMIT = 20000;
	localparam int RANDOM_ITEMS = 135;
	localparam int DIRECTED_ROWS = 25;

	typedef mse_pkg::word_t word_t;

	typedef struct packed {
		word_t value;
		logic  last;
	} sorted_beat_t;

	typedef struct packed {
		word_t value;
		logic  last;
		logic  typed;
		word_t want;
	} stim_row_t;

	logic  clk;
	logic  arst_n = 1'b0;
	logic  s_axis_tvalid = 1'b0;
	logic  s_axis_tready;
	word_t s_axis_tdata = '0;
	logic  s_axis_tlast = 1'b0;
	logic  m_axis_tvalid;
	logic  m_axis_tready = 1'b0;
	word_t m_axis_tdata;
	logic  m_axis_tlast;

	sorted_beat_t sorted_due[$];
	word_t        held_set[$];
	int           mismatches = 0;
	logic         steady_flow = 1'b0;

	stim_row_t directed_rows [DIRECTED_ROWS] = '{
		'{32'sh7FFFFFFF, 1'b1, 1'b1, 32'sh7FFFFFFF},
		'{32'sh80000000, 1'b1, 1'b1, 32'sh80000000},
		'{32'sh00000000, 1'b1, 1'b1, 32'sh00000000},
		'{32'shFFFFFFFF, 1'b1, 1'b1, 32'shFFFFFFFF},
		'{32'sh00000001, 1'b0, 1'b0, 32'sh0},
		'{32'shFFFFFFFF, 1'b1, 1'b0, 32'sh0},
		'{32'sh80000000, 1'b0, 1'b0, 32'sh0},
		'{32'sh7FFFFFFF, 1'b0, 1'b0, 32'sh0},
		'{32'sh00000000, 1'b0, 1'b0, 32'sh0},
		'{32'shFFFFFFFF, 1'b0, 1'b0, 32'sh0},
		'{32'sh00000001, 1'b0, 1'b0, 32'sh0},
		'{32'sh80000000, 1'b1, 1'b0, 32'sh0},
		'{32'sh00000005, 1'b0, 1'b0, 32'sh0},
		'{32'sh00000005, 1'b0, 1'b0, 32'sh0},
		'{32'shFFFFFFFB, 1'b0, 1'b0, 32'sh0},
		'{32'sh00000005, 1'b0, 1'b0, 32'sh0},
		'{32'sh00000005, 1'b1, 1'b0, 32'sh0},
		'{32'sh55555555, 1'b0, 1'b0, 32'sh0},
		'{32'shAAAAAAAA, 1'b0, 1'b0, 32'sh0},
		'{32'sh12345678, 1'b0, 1'b0, 32'sh0},
		'{32'shEDCBA987, 1'b1, 1'b0, 32'sh0},
		'{32'sh00000003, 1'b0, 1'b0, 32'sh0},
		'{32'sh00000002, 1'b0, 1'b0, 32'sh0},
		'{32'sh00000001, 1'b0, 1'b0, 32'sh0},
		'{32'sh00000000, 1'b1, 1'b0, 32'sh0}
	};

	merge_sort_engine #(
		.MAX_ELEMENTS(DEPTH)
	) u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tlast (s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tlast (m_axis_tlast)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	// Stores the value unless the set is full; at the end of a set returns it sorted
	// ascending, equal values kept in arrival order, and starts a new set.
	function automatic void collect_sample(input word_t value, input logic set_end,
			ref word_t sorted[$]);
		int pos;
		sorted = {};
		if (held_set.size() < DEPTH)
			held_set.push_back(value);
		if (set_end) begin
			foreach (held_set[i]) begin
				pos = sorted.size();
				while (pos > 0 && sorted[pos-1] > held_set[i])
					pos--;
				sorted.insert(pos, held_set[i]);
			end
			held_set = {};
		end
	endfunction

	function automatic void queue_sorted(ref word_t sorted[$]);
		sorted_beat_t beat;
		foreach (sorted[i]) begin
			beat.value = sorted[i];
			beat.last = (i == sorted.size() - 1);
			sorted_due.push_back(beat);
		end
	endfunction

	function automatic word_t pick_value(input int unsigned flavor);
		case (flavor)
			0: return word_t'($signed($urandom_range(8)) - 4);
			1: begin
				case ($urandom_range(3))
					0: return 32'sh80000000;
					1: return 32'sh7FFFFFFF;
					2: return 32'sh00000000;
					default: return word_t'($urandom());
				endcase
			end
			default: return word_t'($urandom());
		endcase
	endfunction

	task automatic send_beat(input word_t value, input logic set_end);
		while (!steady_flow && $urandom_range(99) < 30) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= value;
		s_axis_tlast <= set_end;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
	endtask

	always @(posedge clk) begin
		sorted_beat_t want;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (sorted_due.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected beat value %0d last %0b", $realtime,
						m_axis_tdata, m_axis_tlast);
				end else begin
					want = sorted_due.pop_front();
					if (m_axis_tdata !== want.value || m_axis_tlast !== want.last) begin
						mismatches++;
						$display("%0t: expected value %0d last %0b, got value %0d last %0b",
							$realtime, want.value, want.last, m_axis_tdata, m_axis_tlast);
					end
				end
			end
			m_axis_tready <= steady_flow || $urandom_range(99) >= 30;
		end
	end

	initial begin
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("%0t: no beat moved for %0d cycles", $realtime, STALL_LIMIT);
		$display("merge_sort_engine: mismatch");
		$finish;
	end

	initial begin
		word_t       sorted[$];
		word_t       typed_beat[$];
		word_t       value;
		int          random_items;
		int          set_no;
		int          set_len;
		int unsigned flavor;
		random_items = 0;
		set_no = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[r]) begin
			send_beat(directed_rows[r].value, directed_rows[r].last);
			collect_sample(directed_rows[r].value, directed_rows[r].last, sorted);
			if (directed_rows[r].typed) begin
				typed_beat = {directed_rows[r].want};
				queue_sorted(typed_beat);
			end else begin
				queue_sorted(sorted);
			end
		end

		// Set 1 fills the store exactly; set 3 overruns it so that the closing beat is dropped.
		while (random_items < RANDOM_ITEMS) begin
			case (set_no)
				1: set_len = DEPTH;
				3: set_len = DEPTH + $urandom_range(1, 6);
				default: set_len = $urandom_range(1, 10);
			endcase
			steady_flow = (set_no == 1 || set_no == 2);
			flavor = $urandom_range(2);
			for (int i = 0; i < set_len; i++) begin
				value = pick_value(flavor);
				send_beat(value, i == set_len - 1);
				collect_sample(value, i == set_len - 1, sorted);
				queue_sorted(sorted);
			end
			random_items += set_len;
			set_no++;
		end
		s_axis_tvalid <= 1'b0;
		steady_flow = 1'b0;

		while (sorted_due.size() != 0)
			@(posedge clk);
		repeat (64) @(posedge clk);
		if (mismatches == 0 && sorted_due.size() == 0) begin
			$display("merge_sort_engine: match");
		end else begin
			$display("%0t: %0d mismatches, %0d beats still expected", $realtime, mismatches,
				sorted_due.size());
			$display("merge_sort_engine: mismatch");
		end
		$finish;
	end

endmodule
